### hw/rtl/uex_pkg.sv
package uex_pkg;

   localparam int LOOKAHEAD = 11;
   localparam int FILL_W    = $clog2(LOOKAHEAD + 1);
   localparam int IDX_W     = $clog2(LOOKAHEAD);
   localparam int SKIP_W    = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0] byte_type;
   typedef byte_type [LOOKAHEAD-1:0] win_type;

   // one decision job: window snapshot, bytes valid in it, page end pending
   typedef struct packed {
      win_type                win;
      logic [FILL_W-1:0]      fill;
      logic                   flush;
   } job_type;

   typedef enum logic [1:0] {
      KIND_URL_BYTE = 2'd0,
      KIND_URL_END  = 2'd1,
      KIND_PAGE_END = 2'd2
   } kind_type;

   localparam byte_type CH_UPPER_A  = 8'd65;
   localparam byte_type CH_UPPER_Z  = 8'd90;
   localparam byte_type CASE_OFFSET = 8'd32;
   localparam byte_type CH_SPACE    = 8'd32;
   localparam byte_type CH_LT       = 8'd60;
   localparam byte_type CH_GT       = 8'd62;
   localparam byte_type CH_QUOTE    = 8'd34;

   localparam int KW_MAX = 11;
   localparam int KW_W   = 8 * KW_MAX;

   localparam logic [KW_W-1:0] KW_BODY       = "body";
   localparam logic [KW_W-1:0] KW_IMG        = "img";
   localparam logic [KW_W-1:0] KW_BACKGROUND = "background=";
   localparam logic [KW_W-1:0] KW_SRC        = "src=";
   localparam logic [KW_W-1:0] KW_IMG_CLOSE  = "</img>";
   localparam logic [KW_W-1:0] KW_HTTP       = "http:";

   localparam int LEN_BODY       = 4;
   localparam int LEN_IMG        = 3;
   localparam int LEN_BACKGROUND = 11;
   localparam int LEN_SRC        = 4;
   localparam int LEN_IMG_CLOSE  = 6;
   localparam int LEN_HTTP       = 5;

   localparam logic [SKIP_W-1:0] SKIP_BACKGROUND = SKIP_W'(LEN_BACKGROUND - 1);
   localparam logic [SKIP_W-1:0] SKIP_SRC        = SKIP_W'(LEN_SRC - 1);

   function automatic byte_type fold(input byte_type ch);
      return (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) ? ch + CASE_OFFSET : ch;
   endfunction

   // keyword at window head; bytes beyond fill never match
   function automatic logic match_kw(input win_type w, input logic [FILL_W-1:0] fill,
                                     input logic [KW_W-1:0] kw, input int len);
      logic hit;
      int   pos;
      hit = 1'b1;
      pos = 0;
      for (int k = 0; k < KW_MAX; k++) begin
         if (k < len) begin
            pos = len - 1 - k;
            if ((k >= int'(fill)) || (fold(w[k]) != kw[8*pos +: 8])) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

endpackage

### hw/rtl/uex_front.sv
module uex_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_page_byte,
   input  logic              req_page_end,
   input  logic              q_full,
   output logic              q_push,
   output uex_pkg::job_type  q_job
);
   import uex_pkg::*;

   win_type           win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   win_type           win_app;
   logic [FILL_W-1:0] fill_app;
   logic              accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      win_app = win_ff;
      win_app[fill_ff[IDX_W-1:0]] = req_page_byte;
      fill_app = fill_ff + 1'b1;

      win_in  = win_ff;
      fill_in = fill_ff;
      q_push  = 1'b0;
      q_job   = '{win: win_app, fill: fill_app, flush: 1'b0};

      if (accept) begin
         if (req_page_end) begin
            // flush every pending byte, then close the page
            q_push      = 1'b1;
            q_job.flush = 1'b1;
            win_in      = '0;
            fill_in     = '0;
         end else if (fill_app == FILL_W'(LOOKAHEAD)) begin
            q_push  = 1'b1;
            win_in  = win_type'(win_app >> 8);
            fill_in = FILL_W'(LOOKAHEAD - 1);
         end else begin
            win_in  = win_app;
            fill_in = fill_app;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

### hw/rtl/uex_queue.sv
module uex_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  uex_pkg::job_type  push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output uex_pkg::job_type  head_job
);
   import uex_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/uex_back.sv
module uex_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  uex_pkg::job_type  q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_item_kind,
   output logic [7:0]        rsp_url_char,
   output logic              rsp_url_first,
   output logic              rsp_run_last
);
   import uex_pkg::*;

   typedef enum logic [2:0] {
      PH_SCAN  = 3'd0,
      PH_TAG   = 3'd1,
      PH_BODY  = 3'd3,
      PH_IMG   = 3'd4,
      PH_QUOTE = 3'd5,
      PH_URL   = 3'd6
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic              open_ff, open_in;
   job_type           work_ff, work_in;
   logic              busy_ff, busy_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   byte_type          char_ff, char_in;
   logic              first_ff, first_in;
   logic              last_ff, last_in;

   job_type  cur;
   logic     cur_valid;
   logic     out_free;
   logic     step;
   logic     emit;
   byte_type c;

   always_comb begin
      cur       = busy_ff ? work_ff : q_head;
      cur_valid = busy_ff || q_valid;
      out_free  = !rsp_valid_ff || rsp_ready;
      step      = cur_valid && out_free;
      q_pop     = step && !busy_ff;
      c         = cur.win[0];

      phase_in = phase_ff;
      skip_in  = skip_ff;
      open_in  = open_ff;
      work_in  = work_ff;
      busy_in  = busy_ff;
      emit     = 1'b0;
      kind_in  = KIND_URL_BYTE;
      char_in  = '0;
      first_in = 1'b0;
      last_in  = 1'b0;

      if (step) begin
         if (cur.flush && (cur.fill == '0)) begin
            // window drained: close the page and return to reset state
            emit     = 1'b1;
            kind_in  = KIND_PAGE_END;
            last_in  = 1'b1;
            phase_in = PH_SCAN;
            skip_in  = '0;
            open_in  = 1'b0;
            busy_in  = 1'b0;
         end else begin
            last_in = !cur.flush;
            if (skip_ff != '0) begin
               skip_in = skip_ff - 1'b1;
            end else if (c != CH_SPACE) begin
               case (phase_ff)
                  PH_TAG: begin
                     if (match_kw(cur.win, cur.fill, KW_BODY, LEN_BODY)) begin
                        phase_in = PH_BODY;
                     end else if (match_kw(cur.win, cur.fill, KW_IMG, LEN_IMG)) begin
                        phase_in = PH_IMG;
                     end else begin
                        phase_in = PH_SCAN;
                     end
                  end
                  PH_BODY: begin
                     if (match_kw(cur.win, cur.fill, KW_BACKGROUND, LEN_BACKGROUND)) begin
                        skip_in  = SKIP_BACKGROUND;
                        phase_in = PH_QUOTE;
                     end else if (c == CH_GT) begin
                        phase_in = PH_SCAN;
                     end
                  end
                  PH_IMG: begin
                     if (match_kw(cur.win, cur.fill, KW_SRC, LEN_SRC)) begin
                        skip_in  = SKIP_SRC;
                        phase_in = PH_QUOTE;
                     end else if (match_kw(cur.win, cur.fill, KW_IMG_CLOSE, LEN_IMG_CLOSE)) begin
                        phase_in = PH_SCAN;
                     end
                  end
                  PH_QUOTE: begin
                     if (c == CH_QUOTE) begin
                        open_in  = 1'b1;
                        phase_in = PH_URL;
                     end else begin
                        phase_in = PH_SCAN;
                     end
                  end
                  PH_URL: begin
                     if (c == CH_QUOTE) begin
                        // empty url gives no end item
                        if (!open_ff) begin
                           emit    = 1'b1;
                           kind_in = KIND_URL_END;
                        end
                        open_in  = 1'b0;
                        phase_in = PH_SCAN;
                     end else if (open_ff) begin
                        open_in = 1'b0;
                        if (match_kw(cur.win, cur.fill, KW_HTTP, LEN_HTTP)) begin
                           phase_in = PH_SCAN;
                        end else begin
                           emit     = 1'b1;
                           char_in  = c;
                           first_in = 1'b1;
                        end
                     end else begin
                        emit    = 1'b1;
                        char_in = c;
                     end
                  end
                  default: begin
                     phase_in = (c == CH_LT) ? PH_TAG : PH_SCAN;
                  end
               endcase
            end
            if (cur.flush) begin
               work_in.win   = win_type'(cur.win >> 8);
               work_in.fill  = cur.fill - 1'b1;
               work_in.flush = 1'b1;
               busy_in       = 1'b1;
            end else begin
               busy_in = 1'b0;
            end
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         kind_ff  <= kind_in;
         char_ff  <= char_in;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
      if (reset) begin
         phase_ff     <= PH_SCAN;
         skip_ff      <= '0;
         open_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         open_ff      <= open_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item_kind = kind_ff;
   assign rsp_url_char  = char_ff;
   assign rsp_url_first = first_ff;
   assign rsp_run_last  = last_ff;

endmodule

### hw/rtl/html_embedded_url_extractor.sv
// decision: a byte is decided once 10 more bytes have arrived (or at page end);
//   its result passes through the job queue and then the registered output
// throughput: one request per cycle inside a page while the queue is not full; a page-end
//   request holds the decision unit until its whole window is decided and the page closes
// reset: synchronous, active high; clears window fill, queue, parse state and
//   output valid
module html_embedded_url_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_page_byte,
   input  logic       req_page_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_item_kind,
   output logic [7:0] rsp_url_char,
   output logic       rsp_url_first,
   output logic       rsp_run_last
);
   import uex_pkg::*;

   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    q_valid;
   job_type q_head;

   uex_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_page_byte (req_page_byte),
      .req_page_end  (req_page_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (q_job)
   );

   uex_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   uex_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item_kind (rsp_item_kind),
      .rsp_url_char  (rsp_url_char),
      .rsp_url_first (rsp_url_first),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

### hw/rtl/uex_checker.sv
module uex_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_item_kind,
   input logic [7:0] rsp_url_char,
   input logic       rsp_url_first,
   input logic       rsp_run_last
);
   import uex_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_item_kind, rsp_url_char,
                                                        rsp_url_first, rsp_run_last}))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_nonbyte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item_kind != KIND_URL_BYTE) |-> (rsp_url_char == 8'd0) && !rsp_url_first)
      else $error("end item carries url data");

   a_page_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item_kind == KIND_PAGE_END) |-> rsp_run_last)
      else $error("page end not last of its request");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item_kind == KIND_URL_BYTE) || (rsp_item_kind == KIND_URL_END) ||
                    (rsp_item_kind == KIND_PAGE_END))
      else $error("undefined item kind");

endmodule

bind html_embedded_url_extractor uex_checker u_checker (.*);
